FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Each takes a label and expressions on
// signals of the module that uses it; clk and rst must be in scope there.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/rfp_pkg.sv
package rfp_pkg;

  // Field widths.
  localparam int unsigned CoordW = 24;
  localparam int unsigned DirW   = 25;
  localparam int unsigned SqW    = 50;
  localparam int unsigned LenW   = 25;
  localparam int unsigned UnitW  = 16;

  // Pipeline shape.
  localparam int unsigned SqrtStages = LenW;
  localparam int unsigned DivStages  = UnitW;
  localparam int unsigned FracBits   = 15;
  localparam int unsigned NumW       = DirW + FracBits;

  localparam logic [UnitW-1:0] UnitMax = 16'h7FFF;

endpackage

FILE: hw/rtl/rfp_sqrt.sv
// Fully pipelined floor square root, one result bit per stage.
module rfp_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [rfp_pkg::SqW-1:0]        n,
  output logic [rfp_pkg::LenW-1:0]       root
);

  localparam int unsigned RemW = rfp_pkg::LenW + 3;

  logic [RemW-1:0]           rem_r  [rfp_pkg::SqrtStages];
  logic [rfp_pkg::LenW-1:0]  root_r [rfp_pkg::SqrtStages];
  logic [rfp_pkg::SqW-1:0]   n_r    [rfp_pkg::SqrtStages];

  for (genvar k = 0; k < rfp_pkg::SqrtStages; k++) begin : g_stage
    logic [RemW-1:0]          rem_in;
    logic [rfp_pkg::LenW-1:0] root_in;
    logic [rfp_pkg::SqW-1:0]  n_in;
    logic [RemW-1:0]          cat;
    logic [RemW-1:0]          trial;
    logic                     ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = n;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign n_in    = n_r[k-1];
    end

    // Bring down the next two bits and try to subtract 4r+1.
    always_comb begin
      cat   = {rem_in[RemW-3:0], n_in[rfp_pkg::SqW-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      ge    = (cat >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (cat - trial) : cat;
        root_r[k] <= {root_in[rfp_pkg::LenW-2:0], ge};
        n_r[k]    <= {n_in[rfp_pkg::SqW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[rfp_pkg::SqrtStages-1];

endmodule

FILE: hw/rtl/rfp_div.sv
// Pipelined restoring divider: (mag << 15) / len, one quotient bit per stage.
module rfp_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rfp_pkg::DirW-1:0]    mag,
  input  logic [rfp_pkg::LenW-1:0]    len,
  output logic [rfp_pkg::UnitW-1:0]   quot,
  output logic [rfp_pkg::LenW-1:0]    len_out
);

  localparam int unsigned NW = rfp_pkg::NumW;

  logic [NW-1:0]             rem_r [rfp_pkg::DivStages];
  logic [rfp_pkg::UnitW-1:0] q_r   [rfp_pkg::DivStages];
  logic [rfp_pkg::LenW-1:0]  len_r [rfp_pkg::DivStages];

  for (genvar k = 0; k < rfp_pkg::DivStages; k++) begin : g_stage
    localparam int unsigned Sh = rfp_pkg::DivStages - 1 - k;
    logic [NW-1:0]             rem_in;
    logic [rfp_pkg::UnitW-1:0] q_in;
    logic [rfp_pkg::LenW-1:0]  len_in;
    logic [NW-1:0]             sub;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rem_in = {mag, {rfp_pkg::FracBits{1'b0}}};
      assign q_in   = '0;
      assign len_in = len;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign len_in = len_r[k-1];
    end

    // Compare against the divisor shifted to this quotient bit.
    always_comb begin
      sub = {{(NW-rfp_pkg::LenW){1'b0}}, len_in} << Sh;
      ge  = (rem_in >= sub);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_in - sub) : rem_in;
        q_r[k]   <= {q_in[rfp_pkg::UnitW-2:0], ge};
        len_r[k] <= len_in;
      end
    end
  end

  assign quot    = q_r[rfp_pkg::DivStages-1];
  assign len_out = len_r[rfp_pkg::DivStages-1];

endmodule

FILE: hw/rtl/ray_from_two_points.sv
// Channel  Dir  tdata (low bit up)                              tuser
// s_       in   start_x, start_y, start_z, end_x, end_y, end_z  -
// m_       out  dir_x, dir_y, dir_z, ray_length, unit_x/y/z     degenerate
//
// One item is accepted per cycle while the output is not held; each result
// passes through 3 stages of difference, square and sum, 25 root stages,
// 16 divider stages and the output register.
// Reset clears the valid bits only. When the output is held, every stage
// holds with it, so no item is lost or repeated.
`include "assert_macros.svh"

module ray_from_two_points (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,   // dir_x, dir_y, dir_z, ray_length, unit_x,
                                  // unit_y, unit_z, zero fill
  output logic [0:0]   m_tuser    // degenerate
);

  localparam int unsigned DW   = rfp_pkg::DirW;
  localparam int unsigned CW   = rfp_pkg::CoordW;
  localparam int unsigned UW   = rfp_pkg::UnitW;
  localparam int unsigned LW   = rfp_pkg::LenW;
  localparam int unsigned DivIn = 3 + rfp_pkg::SqrtStages;
  localparam int unsigned Last  = DivIn + rfp_pkg::DivStages;
  localparam int unsigned Lat   = Last + 1;

  logic en;
  logic [Lat-1:0] vld;

  logic [3*DW-1:0]         dpipe [1:Last];
  logic [rfp_pkg::SqW-1:0] sq [3];
  logic [rfp_pkg::SqW-1:0] sum;
  logic [LW-1:0]           root;
  logic [UW-1:0]           quot [3];
  logic [LW-1:0]           len_q;
  logic [DW-1:0]           mag_in [3];
  logic [UW-1:0]           unit_next [3];
  logic                    degen_next;
  logic [DW-1:0]           o_dir [3];
  logic [LW-1:0]           o_len;
  logic [UW-1:0]           o_unit [3];
  logic                    o_degen;

  // The whole pipeline moves unless a result is waiting.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[Lat-1];

  // Stage 1: differences.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dpipe[1][i*DW +: DW] <=
          {s_tdata[(i+3)*CW + CW-1], s_tdata[(i+3)*CW +: CW]}
          - {s_tdata[i*CW + CW-1], s_tdata[i*CW +: CW]};
      end
    end
  end

  // Difference vector delay line up to the output register.
  for (genvar k = 2; k <= Last; k++) begin : g_dline
    always_ff @(posedge clk) begin
      if (en) begin
        dpipe[k] <= dpipe[k-1];
      end
    end
  end

  // Stage 2: squares of the magnitudes. Stage 3: sum.
  always_ff @(posedge clk) begin
    logic [DW-1:0] d;
    logic [DW-1:0] m;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d     = dpipe[1][i*DW +: DW];
        m     = d[DW-1] ? (~d + 1'b1) : d;
        sq[i] <= m * m;
      end
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

  rfp_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (sum),
    .root (root)
  );

  // Divider inputs: magnitudes of the differences beside the root.
  always_comb begin
    logic [DW-1:0] d;
    for (int i = 0; i < 3; i++) begin
      d         = dpipe[DivIn][i*DW +: DW];
      mag_in[i] = d[DW-1] ? (~d + 1'b1) : d;
    end
  end

  rfp_div u_div_x (
    .clk(clk), .en(en), .mag(mag_in[0]), .len(root), .quot(quot[0]), .len_out(len_q)
  );
  rfp_div u_div_y (
    .clk(clk), .en(en), .mag(mag_in[1]), .len(root), .quot(quot[1]), .len_out()
  );
  rfp_div u_div_z (
    .clk(clk), .en(en), .mag(mag_in[2]), .len(root), .quot(quot[2]), .len_out()
  );

  // Sign, saturation and the coincident points case.
  always_comb begin
    degen_next = (len_q == '0);
    for (int i = 0; i < 3; i++) begin
      if (degen_next) begin
        unit_next[i] = '0;
      end else if (dpipe[Last][i*DW + DW-1]) begin
        unit_next[i] = ~quot[i] + 1'b1;
      end else if (quot[i] > rfp_pkg::UnitMax) begin
        unit_next[i] = rfp_pkg::UnitMax;
      end else begin
        unit_next[i] = quot[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o_dir[i]  <= dpipe[Last][i*DW +: DW];
        o_unit[i] <= unit_next[i];
      end
      o_len   <= len_q;
      o_degen <= degen_next;
    end
  end

  assign m_tdata = {4'b0, o_unit[2], o_unit[1], o_unit[0], o_len,
                    o_dir[2], o_dir[1], o_dir[0]};
  assign m_tuser = o_degen;

  // A degenerate result carries a zero length and a zero unit vector.
  `ASSERT_IMPLY(a_degen_zero, m_tvalid && m_tuser[0],
                m_tdata[147:75] == '0)
  // A proper result has a non-zero length.
  `ASSERT_IMPLY(a_len_nonzero, m_tvalid && !m_tuser[0], m_tdata[99:75] != '0)
  // A negative x difference never gives a positive unit component.
  `ASSERT_IMPLY(a_sign_x, m_tvalid && !m_tuser[0] && m_tdata[24],
                m_tdata[115] || m_tdata[115:100] == '0)

endmodule
